[hdl/assert_macros.svh]
// Assertion macros shared by the grid line-of-sight RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/gls_pkg.sv]
// Types and constants of the grid line-of-sight block.
// Used by the shared subtract unit and by the top level; depends on nothing.
package gls_pkg;

    localparam int TRIAL_W   = 12;
    localparam int LIN_W     = 18;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int COORD_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic               ge;
        logic [TRIAL_W-1:0] diff;
    } t_trial;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_CLEAR  = 10'b00_0000_0010,
        ST_SQR_X  = 10'b00_0000_0100,
        ST_SQR_Y  = 10'b00_0000_1000,
        ST_ROOT   = 10'b00_0001_0000,
        ST_STEPS  = 10'b00_0010_0000,
        ST_DIV    = 10'b00_0100_0000,
        ST_FIX    = 10'b00_1000_0000,
        ST_SAMPLE = 10'b01_0000_0000,
        ST_FINISH = 10'b10_0000_0000
    } t_state;

endpackage

[hdl/gls_trial_sub.sv]
// Shared trial subtractor: difference and no-borrow flag of two operands.
// Serves the square root, the divisions and their sign fix; depends on gls_pkg.
module gls_trial_sub
    import gls_pkg::*;
(
    input  logic [TRIAL_W-1:0] i_a,
    input  logic [TRIAL_W-1:0] i_b,
    output t_trial             o_res
);

    logic [TRIAL_W:0] w_sub;

    assign w_sub      = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~w_sub[TRIAL_W];
    assign o_res.diff = w_sub[TRIAL_W-1:0];

endmodule

[hdl/gls_mask_ram.sv]
// One-bit occupancy memory with one write port and one registered read port.
// Standalone; instantiated by the top level.
module gls_mask_ram #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic              i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic              o_rdata
);

    logic mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/grid_line_of_sight.sv]
// Grid line-of-sight checker with a one-bit occupancy mask.
// A query works out its step count, at most min(width, height): after squaring, the root, two
// divisions and their sign fixes share one subtractor, then one mask read per cycle. After reset
// a clearing pass over all MAX_WIDTH * MAX_HEIGHT cells blocks every cell before the first word
// is accepted.
module grid_line_of_sight
    import gls_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_kind,
    input  logic [15:0]          i_cell_index,
    input  logic                 i_cell_open,
    input  logic [COORD_W-1:0]   i_from_x,
    input  logic [COORD_W-1:0]   i_from_y,
    input  logic [COORD_W-1:0]   i_to_x,
    input  logic [COORD_W-1:0]   i_to_y,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_visible
);

`include "assert_macros.svh"

    localparam int STORE_CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_CELLS);

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_grid_width, r_grid_height;
    logic [CFG_W-1:0] w_weff, w_heff;

    logic [ADDR_W-1:0] r_clr;

    logic [COORD_W-1:0] r_x0, r_y0, r_adx, r_ady, r_src, r_quo, w_sq_op;
    logic               r_dx_neg, r_dy_neg, r_on_y;
    logic [17:0]        r_d2;
    logic [15:0]        w_sq;
    logic [8:0]         r_root;
    logic [TRIAL_W-1:0] r_rem;
    logic [3:0]         r_cnt;
    logic [9:0]         r_steps, r_tmin, r_i, w_s2, w_steps;
    logic [LIN_W-1:0]   r_area;

    logic signed [9:0] r_qdx, r_qdy, r_qx, r_qy, w_qf, w_x, w_y, n_qx, n_qy, w_q;
    logic [9:0]        r_rdx, r_rdy, r_rx, r_ry, w_rf, n_rx, n_ry;
    logic [10:0]       w_rx_sum, w_ry_sum;
    logic              w_rx_wrap, w_ry_wrap, w_neg, w_rnz, w_issue;

    logic [TRIAL_W-1:0] w_ta, w_tb;
    t_trial             w_tres;

    logic [LIN_W-1:0]  w_lin;
    logic [31:0]       w_lin32, w_widx32;
    logic              w_bad;
    logic              r_v1, r_bad1, r_v2, r_bad2, r_vis;
    logic [ADDR_W-1:0] r_addr1;
    logic              w_rdata;

    logic              w_in_acc, w_we, w_wdata, w_load;
    logic [ADDR_W-1:0] w_waddr;
    logic              r_out_valid, r_out_vis;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_visible   = r_out_vis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= CFG_W'(256);
            r_grid_height <= CFG_W'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_grid_width == '0) begin
            w_weff = CFG_W'(1);
        end else if (32'(r_grid_width) > MAX_WIDTH) begin
            w_weff = CFG_W'(MAX_WIDTH);
        end else begin
            w_weff = r_grid_width;
        end
        if (r_grid_height == '0) begin
            w_heff = CFG_W'(1);
        end else if (32'(r_grid_height) > MAX_HEIGHT) begin
            w_heff = CFG_W'(MAX_HEIGHT);
        end else begin
            w_heff = r_grid_height;
        end
    end

    assign w_sq_op = (r_state == ST_SQR_X) ? r_adx : r_ady;
    assign w_sq    = w_sq_op * w_sq_op;

    always_comb begin
        case (r_state)
            ST_ROOT: begin
                w_ta = TRIAL_W'({r_rem[9:0], r_d2[17:16]});
                w_tb = TRIAL_W'({r_root, 2'b01});
            end
            ST_DIV: begin
                w_ta = TRIAL_W'({r_rem[8:0], r_src[COORD_W-1]});
                w_tb = TRIAL_W'(r_steps);
            end
            ST_FIX: begin
                w_ta = TRIAL_W'(r_steps);
                w_tb = r_rem;
            end
            default: begin
                w_ta = '0;
                w_tb = '0;
            end
        endcase
    end

    gls_trial_sub u_trial (
        .i_a   (w_ta),
        .i_b   (w_tb),
        .o_res (w_tres)
    );

    assign w_s2    = {r_root, 1'b0};
    assign w_steps = (r_tmin < w_s2) ? r_tmin : w_s2;

    // The quotient was taken on the magnitude; floor toward minus infinity for a negative delta.
    assign w_neg = r_on_y ? r_dy_neg : r_dx_neg;
    assign w_rnz = (r_rem != '0);
    assign w_q   = $signed({2'b00, r_quo});
    assign w_qf  = !w_neg ? w_q : (w_rnz ? ~w_q : -w_q);
    assign w_rf  = (w_neg && w_rnz) ? w_tres.diff[9:0] : r_rem[9:0];

    assign w_issue   = (r_i != r_steps);
    assign w_rx_sum  = 11'(r_rx) + 11'(r_rdx);
    assign w_ry_sum  = 11'(r_ry) + 11'(r_rdy);
    assign w_rx_wrap = (w_rx_sum >= 11'(r_steps));
    assign w_ry_wrap = (w_ry_sum >= 11'(r_steps));
    assign n_rx      = w_rx_wrap ? 10'(w_rx_sum - 11'(r_steps)) : w_rx_sum[9:0];
    assign n_ry      = w_ry_wrap ? 10'(w_ry_sum - 11'(r_steps)) : w_ry_sum[9:0];
    assign n_qx      = r_qx + r_qdx + $signed({9'd0, w_rx_wrap});
    assign n_qy      = r_qy + r_qdy + $signed({9'd0, w_ry_wrap});

    assign w_x     = $signed({2'b00, r_x0}) + r_qx;
    assign w_y     = $signed({2'b00, r_y0}) + r_qy;
    assign w_lin   = LIN_W'(w_x[8:0] * w_heff) + LIN_W'(w_y[8:0]);
    assign w_lin32 = 32'(w_lin);
    assign w_bad   = w_x[9] || w_y[9] || (w_lin >= r_area) || (w_lin32 >= STORE_CELLS);

    assign w_widx32 = 32'(i_cell_index);
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = 1'b0;
        end else begin
            w_we    = w_in_acc && (i_kind == KIND_WRITE) && (w_widx32 < STORE_CELLS);
            w_waddr = w_widx32[ADDR_W-1:0];
            w_wdata = i_cell_open;
        end
    end

    gls_mask_ram #(
        .DEPTH  (STORE_CELLS),
        .ADDR_W (ADDR_W)
    ) u_mask (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr1),
        .o_rdata (w_rdata)
    );

    assign w_load = (r_state == ST_FINISH) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == ADDR_W'(STORE_CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc && (i_kind == KIND_QUERY)) begin
                    n_state = ST_SQR_X;
                end
            end
            ST_SQR_X: n_state = ST_SQR_Y;
            ST_SQR_Y: n_state = ST_ROOT;
            ST_ROOT: begin
                if (r_cnt == '0) begin
                    n_state = ST_STEPS;
                end
            end
            ST_STEPS: n_state = (w_steps < 10'd2) ? ST_FINISH : ST_DIV;
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: n_state = r_on_y ? ST_SAMPLE : ST_DIV;
            ST_SAMPLE: begin
                if (!w_issue && !r_v1 && !r_v2) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            r_v1 <= (r_state == ST_SAMPLE) && w_issue;
            r_v2 <= r_v1;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bad1  <= w_bad;
        r_addr1 <= w_bad ? '0 : w_lin32[ADDR_W-1:0];
        r_bad2  <= r_bad1;
        if (w_load) begin
            r_out_vis <= r_vis;
        end
        case (r_state)
            ST_IDLE: begin
                r_x0     <= i_from_x;
                r_y0     <= i_from_y;
                r_dx_neg <= (i_to_x < i_from_x);
                r_dy_neg <= (i_to_y < i_from_y);
                r_adx    <= (i_to_x < i_from_x) ? (i_from_x - i_to_x) : (i_to_x - i_from_x);
                r_ady    <= (i_to_y < i_from_y) ? (i_from_y - i_to_y) : (i_to_y - i_from_y);
                r_area   <= LIN_W'(w_weff * w_heff);
                r_tmin   <= 10'((w_weff < w_heff) ? w_weff : w_heff);
                r_vis    <= 1'b1;
            end
            ST_SQR_X: begin
                r_d2 <= 18'(w_sq);
            end
            ST_SQR_Y: begin
                r_d2   <= r_d2 + 18'(w_sq);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 4'd8;
            end
            ST_ROOT: begin
                r_rem  <= w_tres.ge ? w_tres.diff : w_ta;
                r_root <= {r_root[7:0], w_tres.ge};
                r_d2   <= {r_d2[15:0], 2'b00};
                r_cnt  <= r_cnt - 4'd1;
            end
            ST_STEPS: begin
                r_steps <= w_steps;
                r_rem   <= '0;
                r_quo   <= '0;
                r_cnt   <= 4'd7;
                r_src   <= r_adx;
                r_on_y  <= 1'b0;
            end
            ST_DIV: begin
                r_rem <= w_tres.ge ? w_tres.diff : w_ta;
                r_quo <= {r_quo[6:0], w_tres.ge};
                r_src <= {r_src[6:0], 1'b0};
                r_cnt <= r_cnt - 4'd1;
            end
            ST_FIX: begin
                if (!r_on_y) begin
                    r_qdx  <= w_qf;
                    r_rdx  <= w_rf;
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_cnt  <= 4'd7;
                    r_src  <= r_ady;
                    r_on_y <= 1'b1;
                end else begin
                    r_qdy <= w_qf;
                    r_rdy <= w_rf;
                    r_qx  <= r_qdx;
                    r_rx  <= r_rdx;
                    r_qy  <= w_qf;
                    r_ry  <= w_rf;
                    r_i   <= 10'd1;
                end
            end
            ST_SAMPLE: begin
                if (w_issue) begin
                    r_i  <= r_i + 10'd1;
                    r_qx <= n_qx;
                    r_rx <= n_rx;
                    r_qy <= n_qy;
                    r_ry <= n_ry;
                end
                if (r_v2 && (r_bad2 || !w_rdata)) begin
                    r_vis <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    `GLS_ASSERT_SAME(a_index_bound, r_state == ST_SAMPLE, r_i <= r_steps, "sample index ran past steps")
    `GLS_ASSERT_SAME(a_rem_bound, r_state == ST_SAMPLE, (r_rx < r_steps) && (r_ry < r_steps), "step remainder not below steps")
    `GLS_ASSERT_SAME(a_load_src, $rose(r_out_valid), $past(r_state) == ST_FINISH, "result loaded outside finish")
    `GLS_ASSERT_NEXT(a_pipe_order, !r_v1, !r_v2, "read stage valid without issue stage")

endmodule

[tb/grid_line_of_sight_tb.sv]
// Self-checking testbench for grid_line_of_sight: mask write words and visibility queries.
// A local copy of the occupancy mask and grid size predicts every query result in order.
// Depends on gls_pkg and the grid_line_of_sight RTL.
module grid_line_of_sight_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gls_pkg::*;

    localparam int MAX_W          = 256;
    localparam int MAX_H          = 256;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int HOLD_OFF       = 40;
    localparam int DRAIN_CYCLES   = 400;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = CFG_GRID_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data   = '0;
    logic                 i_in_valid   = 1'b0;
    logic                 i_kind       = KIND_WRITE;
    logic [15:0]          i_cell_index = '0;
    logic                 i_cell_open  = 1'b0;
    logic [COORD_W-1:0]   i_from_x     = '0;
    logic [COORD_W-1:0]   i_from_y     = '0;
    logic [COORD_W-1:0]   i_to_x       = '0;
    logic [COORD_W-1:0]   i_to_y       = '0;
    logic                 i_out_stall  = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_visible;

    bit          occupancy [0:MAX_W*MAX_H-1];
    logic [8:0]  grid_w_reg = 9'd256;
    logic [8:0]  grid_h_reg = 9'd256;
    bit          visible_due [$];

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int error_count     = 0;
    int words_sent      = 0;
    int queries_sent    = 0;
    int results_checked = 0;
    int visible_seen    = 0;
    int idle_cycles     = 0;

    int phase_idle [4]  = '{0, 76, 0, 23};
    int phase_stall [4] = '{0, 0, 76, 23};
    int odd_sizes [5]   = '{0, 1, 256, 300, 511};

    grid_line_of_sight #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_cell_index (i_cell_index),
        .i_cell_open  (i_cell_open),
        .i_from_x     (i_from_x),
        .i_from_y     (i_from_y),
        .i_to_x       (i_to_x),
        .i_to_y       (i_to_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_visible    (o_visible)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        bit want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (o_visible === 1'b1) begin
                visible_seen++;
            end
            if (visible_due.size() == 0) begin
                report_mismatch($sformatf("visible=%b with no query pending", o_visible));
            end else begin
                want = visible_due.pop_front();
                if (o_visible !== want) begin
                    report_mismatch($sformatf("result %0d: visible=%b, predicted %b",
                                              results_checked, o_visible, want));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: %0d cycles without a transfer, %0d queries pending.",
                     idle_cycles, visible_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int effective_size(input logic [8:0] v, input int cap);
        if (v == 0) begin
            return 1;
        end
        return (int'(v) > cap) ? cap : int'(v);
    endfunction

    function automatic int floor_div(input int n, input int d);
        int q;
        q = n / d;
        if (n < 0 && q * d != n) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic bit predict_visible(input logic [7:0] fx, input logic [7:0] fy,
                                           input logic [7:0] tx, input logic [7:0] ty);
        int x0, y0, dx, dy, w, h, area, d2, root, steps, x, y, lin;
        x0 = int'(fx);
        y0 = int'(fy);
        dx = int'(tx) - x0;
        dy = int'(ty) - y0;
        w = effective_size(grid_w_reg, MAX_W);
        h = effective_size(grid_h_reg, MAX_H);
        area = w * h;
        d2 = dx * dx + dy * dy;
        root = 0;
        while ((root + 1) * (root + 1) <= d2) begin
            root++;
        end
        steps = 2 * root;
        if (w < steps) begin
            steps = w;
        end
        if (h < steps) begin
            steps = h;
        end
        for (int i = 1; i < steps; i++) begin
            x = x0 + floor_div(i * dx, steps);
            y = y0 + floor_div(i * dy, steps);
            if (x < 0 || y < 0) begin
                return 1'b0;
            end
            lin = x * h + y;
            if (lin >= area || !occupancy[lin]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic send_word(input logic kind, input logic [15:0] idx, input logic open_v,
                             input logic [7:0] fx, input logic [7:0] fy,
                             input logic [7:0] tx, input logic [7:0] ty);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_cell_index <= idx;
        i_cell_open  <= open_v;
        i_from_x     <= fx;
        i_from_y     <= fy;
        i_to_x       <= tx;
        i_to_y       <= ty;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        words_sent++;
        if (kind == KIND_WRITE) begin
            if (int'(idx) < MAX_W * MAX_H) begin
                occupancy[idx] = open_v;
            end
        end else begin
            queries_sent++;
            visible_due.push_back(predict_visible(fx, fy, tx, ty));
        end
    endtask

    task automatic write_cell(input logic [15:0] idx, input logic open_v);
        send_word(KIND_WRITE, idx, open_v, 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom));
    endtask

    task automatic ask_query(input logic [7:0] fx, input logic [7:0] fy,
                             input logic [7:0] tx, input logic [7:0] ty);
        send_word(KIND_QUERY, 16'($urandom), 1'($urandom), fx, fy, tx, ty);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (visible_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_grid(input logic [8:0] w, input logic [8:0] h);
        drain_results();
        repeat (HOLD_OFF) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_GRID_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        grid_w_reg = w;
        i_cfg_index <= CFG_GRID_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        grid_h_reg = h;
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_write(input int area);
        int top;
        top = area + area / 4;
        if (top > 65535) begin
            top = 65535;
        end
        if ($urandom_range(6) == 0) begin
            write_cell(16'($urandom), 1'($urandom));
        end else begin
            write_cell(16'($urandom_range(0, top)), $urandom_range(9) != 0);
        end
    endtask

    task automatic random_query(input int ew, input int eh);
        if ($urandom_range(6) == 0) begin
            ask_query(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
            ask_query(8'($urandom_range(0, ew - 1)), 8'($urandom_range(0, eh - 1)),
                      8'($urandom_range(0, ew - 1)), 8'($urandom_range(0, eh - 1)));
        end
    endtask

    task automatic test_directed();
        ask_query(8'd0, 8'd0, 8'd0, 8'd0);
        ask_query(8'd255, 8'd255, 8'd255, 8'd255);
        ask_query(8'd0, 8'd0, 8'd255, 8'd255);
        ask_query(8'd255, 8'd0, 8'd0, 8'd255);
        write_cell(16'd0, 1'b1);
        write_cell(16'hFFFF, 1'b1);
        write_cell(16'd1, 1'b1);
        write_cell(16'd2, 1'b1);
        ask_query(8'd0, 8'd0, 8'd0, 8'd3);
        ask_query(8'd0, 8'd3, 8'd0, 8'd0);
        write_cell(16'hFFFF, 1'b0);
        ask_query(8'd255, 8'd254, 8'd255, 8'd255);
    endtask

    task automatic test_size_extremes();
        set_grid(9'd0, 9'd0);
        ask_query(8'd0, 8'd0, 8'd5, 8'd9);
        ask_query(8'd255, 8'd0, 8'd0, 8'd255);
        set_grid(9'd1, 9'd256);
        ask_query(8'd0, 8'd0, 8'd0, 8'd200);
        set_grid(9'd4, 9'd4);
        write_cell(16'd3, 1'b1);
        write_cell(16'd4, 1'b1);
        write_cell(16'd5, 1'b1);
        write_cell(16'd12, 1'b1);
        ask_query(8'd0, 8'd2, 8'd0, 8'd7);
        ask_query(8'd3, 8'd0, 8'd6, 8'd0);
        set_grid(9'd511, 9'd300);
        ask_query(8'd0, 8'd0, 8'd0, 8'd0);
        ask_query(8'd0, 8'd0, 8'd0, 8'd2);
        set_grid(9'd257, 9'd2);
        ask_query(8'd0, 8'd0, 8'd9, 8'd1);
    endtask

    task automatic test_random_scenes(input int scenes);
        int w, h, ew, eh, n_fill, n_mix;
        for (int s = 0; s < scenes; s++) begin
            w = $urandom_range(2, 14);
            h = $urandom_range(2, 14);
            if ($urandom_range(5) == 0) begin
                w = odd_sizes[$urandom_range(4)];
            end else if ($urandom_range(5) == 0) begin
                h = odd_sizes[$urandom_range(4)];
            end
            set_grid(9'(w), 9'(h));
            ew = effective_size(9'(w), MAX_W);
            eh = effective_size(9'(h), MAX_H);
            n_fill = $urandom_range(6, 24);
            n_mix = $urandom_range(15, 30);
            repeat (n_fill) random_write(ew * eh);
            for (int k = 0; k < n_mix; k++) begin
                if (k == n_mix / 2 && $urandom_range(3) == 0) begin
                    drain_results();
                end
                if ($urandom_range(3) == 0) begin
                    random_write(ew * eh);
                end else begin
                    random_query(ew, eh);
                end
            end
        end
    endtask

    task automatic test_long_lines();
        int a, b;
        set_grid(9'd256, 9'd256);
        for (int y = 0; y < 256; y++) begin
            write_cell(16'(7 * 256 + y), 1'b1);
        end
        for (int k = 0; k < 128; k++) begin
            write_cell(16'(k * 257), 1'b1);
        end
        ask_query(8'd7, 8'd0, 8'd7, 8'd255);
        ask_query(8'd127, 8'd127, 8'd0, 8'd0);
        for (int q = 0; q < 30; q++) begin
            a = $urandom_range(255);
            b = $urandom_range(255);
            case ($urandom_range(2))
                0: begin
                    ask_query(8'd7, 8'(a), 8'd7, 8'(b));
                end
                1: begin
                    ask_query(8'(a % 128), 8'(a % 128), 8'(b % 128), 8'(b % 128));
                end
                default: begin
                    ask_query(8'(a), 8'(b), 8'($urandom), 8'($urandom));
                end
            endcase
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_size_extremes();
        for (int p = 0; p < 4; p++) begin
            sender_idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            test_random_scenes(10);
        end
        test_long_lines();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d words including %0d queries; checked %0d results, %0d of them visible.",
                 words_sent, queries_sent, results_checked, visible_seen);
        $display("Grids ranged from 1x1 to 256x256 under four mixes of sender gaps and stalls.");
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/gls_pkg.sv
hdl/gls_trial_sub.sv
hdl/gls_mask_ram.sv
hdl/grid_line_of_sight.sv
tb/grid_line_of_sight_tb.sv
